// ----- hdl/dvru_pkg.sv -----
`timescale 1ns / 1ps

package dvru_pkg;

    // Default table size.
    localparam int TABLE_DEPTH_DEF = 64;

    // Field widths fixed by the word format.
    localparam int ID_W   = 8;
    localparam int COST_W = 10;
    localparam int NBC_W  = 7;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_MY_ID          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEIGHBOR_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFINITY_COST  = 2'd2;

    localparam logic [COST_W-1:0] INFINITY_RESET = 10'd999;

    // Search word that walks along the cell chain. The match index travels
    // beside it because its width follows the table depth.
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   sender;
        logic [ID_W-1:0]   dest;
        logic              found_s;
        logic [COST_W-1:0] link;
        logic              found_d;
        logic [ID_W-1:0]   e_hop;
        logic [COST_W-1:0] e_cost;
    } t_token;

    // Entry write broadcast to all cells; the target index travels beside it.
    typedef struct packed {
        logic              en;
        logic [ID_W-1:0]   dest;
        logic [ID_W-1:0]   hop;
        logic [COST_W-1:0] cost;
    } t_wr;

endpackage

// ----- hdl/distance_vector_route_update.sv -----
`timescale 1ns / 1ps

// Distance-vector route table with split horizon. The table lives in a chain
// of TABLE_DEPTH cells, one entry per cell. A load word is appended as given
// and its result is presented once the finish state finds the output
// register free. An update word sends a search word down the chain, one
// cell per cycle, which picks up the sender's link cost from the neighbor
// entries and the first entry for the destination; the entry is then
// appended or rewritten. An update result waits for the walk down the chain
// and the next word is taken only back in idle. One word is worked on at a
// time; a finished result may wait in the output register while the next
// word is taken in. Configuration is to be written by the user only while
// the block is idle; the block itself does not enforce it.
module distance_vector_route_update
    import dvru_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_mode,
    input  logic [ID_W-1:0]       i_sender_id,
    input  logic [ID_W-1:0]       i_dest_id,
    input  logic [ID_W-1:0]       i_next_hop,
    input  logic [COST_W-1:0]     i_cost,
    input  logic                  i_last,
    // Output channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_entry_added,
    output logic                  o_entry_changed,
    output logic                  o_table_full,
    output logic                  o_sender_unknown,
    output logic                  o_sender_restarted,
    output logic                  o_packet_changed
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_DEPTH);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    // Configuration registers.
    logic [ID_W-1:0]   r_my_id;
    logic [NBC_W-1:0]  r_nb_count;
    logic [COST_W-1:0] r_inf;

    // Control state.
    logic [1:0]        r_state;
    logic [1:0]        n_state;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_seen;
    logic              n_seen;
    logic              r_out_valid;
    logic              n_out_valid;

    // Held input word.
    logic              r_mode;
    logic [ID_W-1:0]   r_sender;
    logic [ID_W-1:0]   r_dest;
    logic [ID_W-1:0]   r_hop;
    logic [COST_W-1:0] r_cost;
    logic              r_last;

    // Search launch and latched search result.
    t_token            r_launch;
    t_token            r_res;
    logic [IDX_W-1:0]  r_res_at;

    // Result register.
    logic [5:0]        r_flags;
    logic [5:0]        n_flags;

    t_token            tok [TABLE_DEPTH+1];
    logic [IDX_W-1:0]  at  [TABLE_DEPTH+1];

    t_wr               wr;
    logic [IDX_W-1:0]  wr_idx;

    logic              in_acc;
    logic              out_free;
    logic [COST_W:0]   sum_wide;
    logic [COST_W-1:0] sum;
    logic              is_full;
    logic              added;
    logic              changed;
    logic              full;
    logic              unknown;
    logic              restarted;
    logic              pkt_changed;
    logic [ID_W-1:0]   u_hop;
    logic [COST_W-1:0] u_cost;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign is_full    = (r_count >= FULL_CNT);

    // Configuration writes; unused indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_id    <= '0;
            r_nb_count <= '0;
            r_inf      <= INFINITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_MY_ID:          r_my_id    <= i_cfg_data[ID_W-1:0];
                CFG_NEIGHBOR_COUNT: r_nb_count <= i_cfg_data[NBC_W-1:0];
                CFG_INFINITY_COST:  r_inf      <= i_cfg_data[COST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Cell chain.
    assign tok[0] = r_launch;
    assign at[0]  = '0;

    generate
        for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
            dvru_cell #(
                .TABLE_DEPTH (TABLE_DEPTH),
                .INDEX       (g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_count    (r_count),
                .i_nb_count (r_nb_count),
                .i_wr       (wr),
                .i_wr_idx   (wr_idx),
                .i_tok      (tok[g]),
                .i_at       (at[g]),
                .o_tok      (tok[g+1]),
                .o_at       (at[g+1])
            );
        end
    endgenerate

    // Saturating sum of link cost and advertised cost.
    always_comb begin
        sum_wide = {1'b0, r_res.link} + {1'b0, r_cost};
        if (sum_wide > {1'b0, r_inf}) begin
            sum = r_inf;
        end else begin
            sum = sum_wide[COST_W-1:0];
        end
    end

    // Decision for the held word, used in the finish state.
    always_comb begin
        added       = 1'b0;
        changed     = 1'b0;
        full        = 1'b0;
        unknown     = 1'b0;
        restarted   = 1'b0;
        pkt_changed = 1'b0;
        wr          = '{en: 1'b0, dest: r_dest, hop: r_hop, cost: r_cost};
        wr_idx      = r_count[IDX_W-1:0];
        u_hop       = r_res.e_hop;
        u_cost      = r_res.e_cost;
        n_seen      = r_seen;
        if (!r_mode) begin
            // Load word: append exactly as given.
            if (is_full) begin
                full = 1'b1;
            end else begin
                wr.en = 1'b1;
            end
        end else begin
            if (!r_res.found_s) begin
                unknown = 1'b1;
            end else begin
                restarted = (r_res.link == r_inf);
                if (!r_res.found_d) begin
                    // New destination reached via the sender.
                    wr.hop  = r_sender;
                    wr.cost = sum;
                    if (is_full) begin
                        full = 1'b1;
                    end else begin
                        wr.en = 1'b1;
                        added = 1'b1;
                    end
                end else if (r_hop != r_my_id) begin
                    // Cheaper path first, then forced update from next hop.
                    if (sum < u_cost) begin
                        u_hop   = r_sender;
                        u_cost  = sum;
                        changed = 1'b1;
                    end
                    if ((u_hop == r_sender) && (u_cost != sum)) begin
                        u_cost  = sum;
                        changed = 1'b1;
                    end
                    wr.en   = 1'b1;
                    wr.hop  = u_hop;
                    wr.cost = u_cost;
                    wr_idx  = r_res_at;
                end
            end
            if (added || changed) begin
                n_seen = 1'b1;
            end
            if (r_last) begin
                pkt_changed = n_seen;
                n_seen      = 1'b0;
            end
        end
        // Only commit when the result can be stored.
        if (r_state != ST_FINISH || !out_free) begin
            wr.en  = 1'b0;
            n_seen = r_seen;
        end
    end

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && i_out_stall;
        n_flags     = r_flags;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = i_mode ? ST_SEARCH : ST_FINISH;
                end
            end
            ST_SEARCH: begin
                if (tok[TABLE_DEPTH].valid) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state     = ST_IDLE;
                    n_out_valid = 1'b1;
                    n_flags     = {pkt_changed, restarted, unknown, full, changed, added};
                    if (wr.en && (!r_mode || added)) begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers and the launch word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_count        <= '0;
            r_seen         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_launch.valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_count        <= n_count;
            r_seen         <= n_seen;
            r_out_valid    <= n_out_valid;
            r_launch.valid <= in_acc && i_mode;
        end
        r_launch.sender  <= i_sender_id;
        r_launch.dest    <= i_dest_id;
        r_launch.found_s <= 1'b0;
        r_launch.link    <= '0;
        r_launch.found_d <= 1'b0;
        r_launch.e_hop   <= '0;
        r_launch.e_cost  <= '0;
    end

    // Payload registers: held word, search result, flags.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode   <= i_mode;
            r_sender <= i_sender_id;
            r_dest   <= i_dest_id;
            r_hop    <= i_next_hop;
            r_cost   <= i_cost;
            r_last   <= i_last;
        end
        if (r_state == ST_SEARCH && tok[TABLE_DEPTH].valid) begin
            r_res    <= tok[TABLE_DEPTH];
            r_res_at <= at[TABLE_DEPTH];
        end
        r_flags <= n_flags;
    end

    assign o_out_valid        = r_out_valid;
    assign o_entry_added      = r_flags[0];
    assign o_entry_changed    = r_flags[1];
    assign o_table_full       = r_flags[2];
    assign o_sender_unknown   = r_flags[3];
    assign o_sender_restarted = r_flags[4];
    assign o_packet_changed   = r_flags[5];

    // The route count never passes the table size.
    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("route count beyond table size");

    // A search word leaves the chain only while the sequencer waits for it.
    a_tok_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tok[TABLE_DEPTH].valid |-> r_state == ST_SEARCH)
        else $error("search word arrived outside search state");

    // A destination match always points at a used entry.
    a_at_used : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tok[TABLE_DEPTH].valid && tok[TABLE_DEPTH].found_d)
            |-> CNT_W'(at[TABLE_DEPTH]) < r_count)
        else $error("destination match beyond route count");

    // At most one of the added, changed, full and unknown flags describes a word.
    a_outcome : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0({o_entry_added, o_entry_changed,
                                  o_table_full, o_sender_unknown}))
        else $error("conflicting outcome flags");

    // An accepted update word starts a walk down the chain.
    a_launch : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_mode) |=> (r_launch.valid && r_state == ST_SEARCH))
        else $error("update word did not start a search");

endmodule

// ----- hdl/dvru_cell.sv -----
`timescale 1ns / 1ps

module dvru_cell
    import dvru_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int INDEX       = 0,
    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CNT_W-1:0]  i_count,
    input  logic [NBC_W-1:0]  i_nb_count,
    input  t_wr               i_wr,
    input  logic [IDX_W-1:0]  i_wr_idx,
    input  t_token            i_tok,
    input  logic [IDX_W-1:0]  i_at,
    output t_token            o_tok,
    output logic [IDX_W-1:0]  o_at
);

    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_CNT  = CNT_W'(INDEX);
    localparam logic [8:0]       MY_IDX9 = 9'(INDEX);

    // Entry held by this cell.
    logic [ID_W-1:0]   r_dest;
    logic [ID_W-1:0]   r_hop;
    logic [COST_W-1:0] r_cost;

    t_token            r_tok;
    t_token            n_tok;
    logic [IDX_W-1:0]  r_at;
    logic [IDX_W-1:0]  n_at;

    logic              in_use;
    logic              is_nb;

    assign in_use = MY_CNT < i_count;
    assign is_nb  = in_use && (MY_IDX9 < {2'b00, i_nb_count});

    // Entry write when the broadcast targets this cell.
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr_idx == MY_IDX)) begin
            r_dest <= i_wr.dest;
            r_hop  <= i_wr.hop;
            r_cost <= i_wr.cost;
        end
    end

    // Compare the passing word with this entry; earlier cells win.
    always_comb begin
        n_tok = i_tok;
        n_at  = i_at;
        if (i_tok.valid) begin
            if (is_nb && !i_tok.found_s && (r_dest == i_tok.sender)) begin
                n_tok.found_s = 1'b1;
                n_tok.link    = r_cost;
            end
            if (in_use && !i_tok.found_d && (r_dest == i_tok.dest)) begin
                n_tok.found_d = 1'b1;
                n_tok.e_hop   = r_hop;
                n_tok.e_cost  = r_cost;
                n_at          = MY_IDX;
            end
        end
    end

    // Hand the word to the next cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.sender  <= n_tok.sender;
        r_tok.dest    <= n_tok.dest;
        r_tok.found_s <= n_tok.found_s;
        r_tok.link    <= n_tok.link;
        r_tok.found_d <= n_tok.found_d;
        r_tok.e_hop   <= n_tok.e_hop;
        r_tok.e_cost  <= n_tok.e_cost;
        r_at          <= n_at;
    end

    assign o_tok = r_tok;
    assign o_at  = r_at;

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
    import dvru_pkg::*;

    localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;

    // Word kinds on the input channel.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_UPDATE = 1'b1;

    // Register index that maps to no register.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // An update walks the whole chain, so this covers one word in flight.
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
    localparam int CYCLE_LIMIT   = 1000000;

    // The receiver holds off once, after this many results, for this long.
    localparam int HOLD_AT  = 200;
    localparam int HOLD_LEN = 400;

    typedef struct packed {
        logic              mode;
        logic [ID_W-1:0]   sender;
        logic [ID_W-1:0]   dest;
        logic [ID_W-1:0]   hop;
        logic [COST_W-1:0] cost;
        logic              last;
    } route_word_t;

    typedef struct packed {
        logic added;
        logic changed;
        logic full;
        logic unknown;
        logic restarted;
        logic pkt_changed;
    } route_flags_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_entry_added;
    logic                  o_entry_changed;
    logic                  o_table_full;
    logic                  o_sender_unknown;
    logic                  o_sender_restarted;
    logic                  o_packet_changed;

    route_word_t offered_word = '0;

    // Route words still to be offered, and flags still to arrive.
    route_word_t  route_words_q[$];
    route_flags_t expected_flags[$];
    route_flags_t due_flags;

    // Predicted table and register copies.
    logic [ID_W-1:0]   tbl_dest [TABLE_DEPTH];
    logic [ID_W-1:0]   tbl_hop  [TABLE_DEPTH];
    logic [COST_W-1:0] tbl_cost [TABLE_DEPTH];
    int unsigned       tbl_count = 0;
    bit                change_in_packet = 1'b0;
    logic [ID_W-1:0]   cfg_my_id = '0;
    logic [NBC_W-1:0]  cfg_nbc = '0;
    logic [COST_W-1:0] cfg_inf = INFINITY_RESET;

    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;
    bit          idle_enabled = 1'b1;
    int unsigned cycle_count = 0;

    distance_vector_route_update #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (offered_word.mode),
        .i_sender_id       (offered_word.sender),
        .i_dest_id         (offered_word.dest),
        .i_next_hop        (offered_word.hop),
        .i_cost            (offered_word.cost),
        .i_last            (offered_word.last),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_entry_added     (o_entry_added),
        .o_entry_changed   (o_entry_changed),
        .o_table_full      (o_table_full),
        .o_sender_unknown  (o_sender_unknown),
        .o_sender_restarted(o_sender_restarted),
        .o_packet_changed  (o_packet_changed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly short idle runs, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_enabled || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 80);
    endfunction

    // Costs lean toward small values and the saturation points.
    function automatic logic [COST_W-1:0] pick_cost();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return COST_W'($urandom_range(0, 15));
        else if (r < 55)
            return '0;
        else if (r < 65)
            return '1;
        else if (r < 75)
            return cfg_inf;
        else
            return COST_W'($urandom_range(0, 1023));
    endfunction

    function automatic route_word_t make_word(logic mode, logic [ID_W-1:0] sender,
                                              logic [ID_W-1:0] dest, logic [ID_W-1:0] hop,
                                              logic [COST_W-1:0] cost, logic last);
        route_word_t w;
        w.mode   = mode;
        w.sender = sender;
        w.dest   = dest;
        w.hop    = hop;
        w.cost   = cost;
        w.last   = last;
        return w;
    endfunction

    // Appends an entry unless the table is full.
    function automatic bit store_route(logic [ID_W-1:0] dest, logic [ID_W-1:0] hop,
                                       logic [COST_W-1:0] cost);
        if (tbl_count >= TABLE_DEPTH)
            return 1'b0;
        tbl_dest[tbl_count] = dest;
        tbl_hop[tbl_count]  = hop;
        tbl_cost[tbl_count] = cost;
        tbl_count++;
        return 1'b1;
    endfunction

    // Applies one accepted word to the predicted table and returns its flags.
    function automatic route_flags_t update_route_table(route_word_t w);
        route_flags_t      f;
        int unsigned       nb;
        int unsigned       at;
        bit                have_link;
        bit                found;
        logic [COST_W-1:0] link;
        logic [COST_W:0]   sum;
        logic [ID_W-1:0]   e_hop;
        logic [COST_W-1:0] e_cost;
        f = '0;
        have_link = 1'b0;
        found = 1'b0;
        link = '0;
        at = 0;
        if (w.mode == MODE_LOAD) begin
            // Loads go in as given, with no duplicate check and no clamping.
            if (!store_route(w.dest, w.hop, w.cost))
                f.full = 1'b1;
        end else begin
            // The sender is looked up only among the leading neighbor entries.
            nb = (32'(cfg_nbc) < tbl_count) ? 32'(cfg_nbc) : tbl_count;
            for (int i = 0; i < nb; i++) begin
                if (!have_link && tbl_dest[i] == w.sender) begin
                    link = tbl_cost[i];
                    have_link = 1'b1;
                end
            end
            if (!have_link) begin
                f.unknown = 1'b1;
            end else begin
                f.restarted = (link == cfg_inf);
                sum = {1'b0, link} + {1'b0, w.cost};
                if (sum > {1'b0, cfg_inf})
                    sum = {1'b0, cfg_inf};
                for (int i = 0; i < tbl_count; i++) begin
                    if (!found && tbl_dest[i] == w.dest) begin
                        found = 1'b1;
                        at = i;
                    end
                end
                if (!found) begin
                    if (store_route(w.dest, w.sender, sum[COST_W-1:0]))
                        f.added = 1'b1;
                    else
                        f.full = 1'b1;
                end else if (w.hop != cfg_my_id) begin
                    // Take a cheaper path, then force the cost when the
                    // sender is the next hop.
                    e_hop  = tbl_hop[at];
                    e_cost = tbl_cost[at];
                    if (sum[COST_W-1:0] < e_cost) begin
                        e_hop  = w.sender;
                        e_cost = sum[COST_W-1:0];
                        f.changed = 1'b1;
                    end
                    if (e_hop == w.sender && e_cost != sum[COST_W-1:0]) begin
                        e_cost = sum[COST_W-1:0];
                        f.changed = 1'b1;
                    end
                    tbl_hop[at]  = e_hop;
                    tbl_cost[at] = e_cost;
                end
            end
            if (f.added || f.changed)
                change_in_packet = 1'b1;
            if (w.last) begin
                f.pkt_changed = change_in_packet;
                change_in_packet = 1'b0;
            end
        end
        return f;
    endfunction

    task automatic compare_flag(string name, logic want, logic got);
        if (got !== want) begin
            $error("%s: expected %0b, got %0b", name, want, got);
            mismatch_count++;
        end
    endtask

    // Sender: offers queued words, with idle gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                expected_flags.push_back(update_route_table(offered_word));
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap != 0) begin
                    send_gap   <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (route_words_q.size() != 0) begin
                    offered_word <= route_words_q.pop_front();
                    i_in_valid   <= 1'b1;
                    send_gap     <= pick_gap();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result word and stalls at random.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            results_seen <= results_seen + 1;
            if (expected_flags.size() == 0) begin
                $error("result word arrived with no expected flags waiting");
                mismatch_count++;
            end else begin
                due_flags = expected_flags.pop_front();
                compare_flag("entry_added", due_flags.added, o_entry_added);
                compare_flag("entry_changed", due_flags.changed, o_entry_changed);
                compare_flag("table_full", due_flags.full, o_table_full);
                compare_flag("sender_unknown", due_flags.unknown, o_sender_unknown);
                compare_flag("sender_restarted", due_flags.restarted, o_sender_restarted);
                compare_flag("packet_changed", due_flags.pkt_changed, o_packet_changed);
            end
        end
        // One long hold-off lets the block back up into its input.
        if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen == HOLD_AT) begin
            hold_left   <= HOLD_LEN;
            hold_done   <= 1'b1;
            i_out_stall <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            stall_left  <= pick_gap();
            i_out_stall <= 1'b0;
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Waits until every word is taken and every result has come back.
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (route_words_q.size() != 0 || i_in_valid || expected_flags.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MY_ID:          cfg_my_id = val[ID_W-1:0];
            CFG_NEIGHBOR_COUNT: cfg_nbc = val[NBC_W-1:0];
            CFG_INFINITY_COST:  cfg_inf = val[COST_W-1:0];
            default:            ; // an index with no register is ignored
        endcase
    endtask

    task automatic set_routing(logic [ID_W-1:0] me, logic [NBC_W-1:0] nbc,
                               logic [COST_W-1:0] inf);
        write_reg(CFG_MY_ID, CFG_DATA_W'(me));
        write_reg(CFG_NEIGHBOR_COUNT, CFG_DATA_W'(nbc));
        write_reg(CFG_INFINITY_COST, inf);
    endtask

    // Random traffic: mostly packets from a known neighbor, some stray
    // updates and a few loads. Some packets are cut off without a last word.
    task automatic queue_random_routes(int unsigned n_words);
        int unsigned     made;
        int unsigned     nb;
        int unsigned     len;
        int unsigned     r;
        logic [ID_W-1:0] from;
        logic [ID_W-1:0] dest;
        logic [ID_W-1:0] hop;
        made = 0;
        nb = (32'(cfg_nbc) < tbl_count) ? 32'(cfg_nbc) : tbl_count;
        while (made < n_words) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                route_words_q.push_back(make_word(MODE_LOAD, ID_W'($urandom_range(0, 255)),
                    ID_W'($urandom_range(0, 255)), ID_W'($urandom_range(0, 255)),
                    pick_cost(), 1'($urandom_range(0, 1))));
                made++;
            end else if (r < 12 || nb == 0) begin
                route_words_q.push_back(make_word(MODE_UPDATE, ID_W'($urandom_range(0, 255)),
                    ID_W'($urandom_range(0, 255)), ID_W'($urandom_range(0, 255)),
                    pick_cost(), 1'($urandom_range(0, 1))));
                made++;
            end else begin
                from = tbl_dest[$urandom_range(0, nb - 1)];
                len = $urandom_range(1, 6);
                for (int k = 0; k < len; k++) begin
                    r = $urandom_range(0, 99);
                    if (r < 70)
                        dest = ID_W'($urandom_range(0, 47));
                    else if (r < 85)
                        dest = tbl_dest[$urandom_range(0, nb - 1)];
                    else
                        dest = ID_W'($urandom_range(0, 255));
                    hop = ($urandom_range(0, 4) == 0) ? cfg_my_id
                                                      : ID_W'($urandom_range(0, 255));
                    route_words_q.push_back(make_word(MODE_UPDATE, from, dest, hop,
                        pick_cost(), k == len - 1 && $urandom_range(0, 9) != 0));
                end
                made += len;
            end
        end
    endtask

    task automatic run_phase(logic [ID_W-1:0] me, logic [NBC_W-1:0] nbc,
                             logic [COST_W-1:0] inf, bit gaps, int unsigned n_words);
        wait_idle();
        set_routing(me, nbc, inf);
        idle_enabled = gaps;
        @(negedge i_clk);
        queue_random_routes(n_words);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // With reset registers nobody is a neighbor yet.
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd5, 8'd7, 8'd0, 10'd1, 1'b1));
        route_words_q.push_back(make_word(MODE_LOAD, 8'd0, 8'd5, 8'd5, 10'd3, 1'b0));
        route_words_q.push_back(make_word(MODE_LOAD, 8'd0, 8'd255, 8'd255, 10'd999, 1'b0));
        route_words_q.push_back(make_word(MODE_LOAD, 8'd0, 8'd0, 8'd0, 10'd1023, 1'b0));
        route_words_q.push_back(make_word(MODE_LOAD, 8'd0, 8'd5, 8'd5, 10'd20, 1'b0));
        route_words_q.push_back(make_word(MODE_LOAD, 8'd0, 8'd9, 8'd9, 10'd0, 1'b0));
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd5, 8'd7, 8'd0, 10'd1, 1'b1));

        // Neighbor count equal to the table size; a write to the spare index.
        wait_idle();
        write_reg(CFG_UNUSED, 10'h3FF);
        set_routing(8'd200, 7'd64, 10'd999);
        @(negedge i_clk);
        // Append, no-op repeat, cheaper path, split horizon, forced update.
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd5, 8'd40, 8'd1, 10'd10, 1'b0));
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd5, 8'd40, 8'd1, 10'd10, 1'b0));
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd9, 8'd40, 8'd3, 10'd2, 1'b0));
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd5, 8'd40, 8'd200, 10'd0, 1'b0));
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd9, 8'd40, 8'd1, 10'd50, 1'b1));
        // Link cost at infinity, then a loaded link beyond infinity.
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd255, 8'd41, 8'd0, 10'd0, 1'b1));
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd0, 8'd42, 8'd0, 10'd1023, 1'b0));
        // A load inside a packet, then an unknown sender ends the packet.
        route_words_q.push_back(make_word(MODE_LOAD, 8'd0, 8'd99, 8'd99, 10'd1023, 1'b1));
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd77, 8'd3, 8'd0, 10'd0, 1'b1));
        // Neighbor rewrites its own entry; the duplicate entry stays unused.
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd5, 8'd5, 8'd2, 10'd1023, 1'b1));
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd5, 8'd42, 8'd7, 10'd4, 1'b1));
        route_words_q.push_back(make_word(MODE_UPDATE, 8'd9, 8'd255, 8'd255, 10'd1023, 1'b1));

        run_phase(8'd255, 7'd6, 10'd1023, 1'b1, 150);
        run_phase(8'd0, 7'd3, 10'd1, 1'b1, 120);
        run_phase(8'd0, 7'd0, 10'd999, 1'b1, 20);
        run_phase(8'd17, 7'd64, 10'd500, 1'b0, 150);
        run_phase(ID_W'($urandom_range(0, 255)), NBC_W'($urandom_range(1, 64)),
                  COST_W'($urandom_range(1, 1023)), 1'b1, 150);

        wait_idle();
        if (mismatch_count == 0 && expected_flags.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
